// ===== hdl/sier_pkg.sv =====
// Package with shared types, codes and defaults of the shift input event resolver.
package sier_pkg;

    localparam int C_GROUPS      = 16;
    localparam int C_MOM_ENTRIES = 32;
    localparam int C_SEL_ENTRIES = 64;

    localparam logic [15:0] C_CACHE_UNKNOWN = 16'hFFFF;
    localparam logic [6:0]  C_FALLBACK_BIT  = 7'h7F;

    // Request kinds.
    typedef enum logic [2:0] {
        K_CLEAR_TABLES = 3'd0,
        K_ADD_MOM      = 3'd1,
        K_ADD_SEL      = 3'd2,
        K_SNAPSHOT     = 3'd3,
        K_CLEAR_CACHE  = 3'd4
    } t_kind;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOM_RD,
        S_MOM_EV,
        S_SEL_RD,
        S_SEL_EV,
        S_GRP_RD,
        S_GRP_EV,
        S_DONE
    } t_state;

    // Table load request from the sequencer.
    typedef struct packed {
        logic        clear;
        logic        add_mom;
        logic        add_sel;
        logic [6:0]  bit_pos;
        logic [3:0]  grp;
        logic [15:0] value;
    } t_load;

    // One event handed to the output stage.
    typedef struct packed {
        logic        kind;
        logic [5:0]  index;
        logic [3:0]  grp;
        logic [15:0] value;
        logic        pressed;
        logic        forced;
    } t_evt;

endpackage

// ===== hdl/shift_input_event_resolver_core.sv =====
// Top level of the shift input event resolver: sequencer, group state and ports.
// Load and cache requests leave o_busy low; a snapshot holds o_busy while the sequencer walks the
// momentary entries, the selector entries and then groups 1 to GROUPS-1, reading each entry through
// the registered read port of its memory, entry by entry, and emitting for groups with a pick.
// Each event leaves in the cycle after the next one is found, the last one just after the walk.
// Reset is synchronous, active low: tables empty, fallbacks invalid, caches unknown, mask zero.
module shift_input_event_resolver_core #(
    parameter int GROUPS      = sier_pkg::C_GROUPS,
    parameter int MOM_ENTRIES = sier_pkg::C_MOM_ENTRIES,
    parameter int SEL_ENTRIES = sier_pkg::C_SEL_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_current_bits,
    input  logic [63:0] i_previous_bits,
    input  logic        i_force_send,
    input  logic signed [6:0] i_entry_bit,
    input  logic [3:0]  i_entry_group,
    input  logic [15:0] i_entry_value,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic        o_event_kind,
    output logic [5:0]  o_entry_index,
    output logic [3:0]  o_group_number,
    output logic [15:0] o_position_value,
    output logic        o_pressed,
    output logic        o_forced,
    output logic        o_last_event
);

    localparam int MIW = (MOM_ENTRIES > 1) ? $clog2(MOM_ENTRIES) : 1;
    localparam int SIW = (SEL_ENTRIES > 1) ? $clog2(SEL_ENTRIES) : 1;
    localparam int MCW = $clog2(MOM_ENTRIES + 1);
    localparam int SCW = $clog2(SEL_ENTRIES + 1);
    localparam int GW  = $clog2(GROUPS);
    localparam int GCW = $clog2(GROUPS + 1);

    sier_pkg::t_state r_state, n_state;
    sier_pkg::t_load  load;
    sier_pkg::t_evt   evt;

    logic [63:0]    r_invert;
    logic [63:0]    r_cur, r_prev;
    logic           r_force;
    logic [MCW-1:0] r_mi;
    logic [SCW-1:0] r_si;
    logic [GCW-1:0] r_g;
    logic [SIW-1:0] r_pick;
    logic [GROUPS-1:0] r_has_win;
    logic [SIW-1:0]    r_win [GROUPS];
    logic [GROUPS-1:0] r_fb_valid;
    logic [SIW-1:0]    r_fb_idx [GROUPS];
    logic [GROUPS-1:0] r_cache_known;
    logic [15:0]       r_cache [GROUPS];

    logic [MIW-1:0] mom_addr;
    logic [SIW-1:0] sel_addr;
    logic [5:0]     mom_rdata;
    logic [26:0]    sel_rdata;
    logic [MCW-1:0] mom_count;
    logic [SCW-1:0] sel_count;
    logic           sel_wr;
    logic [SIW-1:0] sel_wr_idx;
    logic           accept;
    logic           emit, flush;
    logic           mom_now, mom_was;
    logic [GW-1:0]  g_ix, ld_gix, sel_gix;
    logic           g_has_pick;
    logic [SIW-1:0] g_pick;
    logic [15:0]    cache_val;
    logic           sel_hit;

    assign accept = i_start && (r_state == sier_pkg::S_IDLE);
    assign o_busy = (r_state != sier_pkg::S_IDLE);

    // Load request to the tables.
    always_comb begin
        load.clear   = accept && (sier_pkg::t_kind'(i_kind) == sier_pkg::K_CLEAR_TABLES);
        load.add_mom = accept && (sier_pkg::t_kind'(i_kind) == sier_pkg::K_ADD_MOM);
        load.add_sel = accept && (sier_pkg::t_kind'(i_kind) == sier_pkg::K_ADD_SEL);
        load.bit_pos = i_entry_bit;
        load.grp     = i_entry_group;
        load.value   = i_entry_value;
    end

    sier_tables #(
        .GROUPS      (GROUPS),
        .MOM_ENTRIES (MOM_ENTRIES),
        .SEL_ENTRIES (SEL_ENTRIES)
    ) u_tables (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_mom_addr   (mom_addr),
        .i_sel_addr   (sel_addr),
        .o_mom_rdata  (mom_rdata),
        .o_sel_rdata  (sel_rdata),
        .o_mom_count  (mom_count),
        .o_sel_count  (sel_count),
        .o_sel_wr     (sel_wr),
        .o_sel_wr_idx (sel_wr_idx)
    );

    // Group lookups shared by the walks.
    always_comb begin
        g_ix       = r_g[GW-1:0];
        ld_gix     = GW'(i_entry_group);
        sel_gix    = GW'(sel_rdata[19:16]);
        g_has_pick = r_has_win[g_ix] || r_fb_valid[g_ix];
        g_pick     = r_has_win[g_ix] ? r_win[g_ix] : r_fb_idx[g_ix];
        cache_val  = r_cache_known[g_ix] ? r_cache[g_ix] : sier_pkg::C_CACHE_UNKNOWN;
        mom_now    = !r_cur[mom_rdata];
        mom_was    = !r_prev[mom_rdata];
        sel_hit    = !sel_rdata[26] && (32'(sel_rdata[19:16]) < GROUPS)
                     && !r_has_win[sel_gix] && !r_cur[sel_rdata[25:20]];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sier_pkg::S_IDLE: begin
                if (accept && sier_pkg::t_kind'(i_kind) == sier_pkg::K_SNAPSHOT) begin
                    n_state = sier_pkg::S_MOM_RD;
                end
            end
            sier_pkg::S_MOM_RD: begin
                n_state = (r_mi == mom_count) ? sier_pkg::S_SEL_RD : sier_pkg::S_MOM_EV;
            end
            sier_pkg::S_MOM_EV: n_state = sier_pkg::S_MOM_RD;
            sier_pkg::S_SEL_RD: begin
                n_state = (r_si == sel_count) ? sier_pkg::S_GRP_RD : sier_pkg::S_SEL_EV;
            end
            sier_pkg::S_SEL_EV: n_state = sier_pkg::S_SEL_RD;
            sier_pkg::S_GRP_RD: begin
                if (r_g == GCW'(GROUPS)) begin
                    n_state = sier_pkg::S_DONE;
                end else if (g_has_pick) begin
                    n_state = sier_pkg::S_GRP_EV;
                end
            end
            sier_pkg::S_GRP_EV: n_state = sier_pkg::S_GRP_RD;
            sier_pkg::S_DONE:   n_state = sier_pkg::S_IDLE;
            default:            n_state = sier_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: read addresses and events.
    always_comb begin
        mom_addr    = r_mi[MIW-1:0];
        sel_addr    = (r_state == sier_pkg::S_GRP_RD) ? g_pick : r_si[SIW-1:0];
        emit        = 1'b0;
        flush       = 1'b0;
        evt         = '0;
        evt.forced  = r_force;
        case (r_state)
            sier_pkg::S_MOM_EV: begin
                emit        = r_force || (mom_now != mom_was);
                evt.kind    = 1'b0;
                evt.index   = 6'(r_mi);
                evt.pressed = mom_now;
            end
            sier_pkg::S_GRP_EV: begin
                emit        = r_force || (cache_val != sel_rdata[15:0]);
                evt.kind    = 1'b1;
                evt.index   = 6'(r_pick);
                evt.grp     = 4'(r_g);
                evt.value   = sel_rdata[15:0];
                evt.pressed = 1'b1;
            end
            sier_pkg::S_DONE: flush = 1'b1;
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers and group state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sier_pkg::S_IDLE;
            r_invert      <= '0;
            r_fb_valid    <= '0;
            r_cache_known <= '0;
            r_has_win     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_invert <= i_cfg_wdata;
            end
            if (load.clear) begin
                r_fb_valid    <= '0;
                r_cache_known <= '0;
            end
            if (accept && sier_pkg::t_kind'(i_kind) == sier_pkg::K_CLEAR_CACHE) begin
                r_cache_known <= '0;
            end
            if (sel_wr && i_entry_bit == sier_pkg::C_FALLBACK_BIT && !r_fb_valid[ld_gix]) begin
                r_fb_valid[ld_gix] <= 1'b1;
            end
            if (accept) begin
                r_has_win <= '0;
            end
            if (r_state == sier_pkg::S_SEL_EV && sel_hit) begin
                r_has_win[sel_gix] <= 1'b1;
            end
            if (r_state == sier_pkg::S_GRP_EV) begin
                r_cache_known[g_ix] <= 1'b1;
            end
        end
    end

    // Working registers of the walk.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur   <= i_current_bits ^ r_invert;
            r_prev  <= i_previous_bits ^ r_invert;
            r_force <= i_force_send;
            r_mi    <= '0;
            r_si    <= '0;
            r_g     <= GCW'(1);
        end
        if (r_state == sier_pkg::S_MOM_EV) begin
            r_mi <= r_mi + MCW'(1);
        end
        if (r_state == sier_pkg::S_SEL_EV) begin
            r_si <= r_si + SCW'(1);
            if (sel_hit) begin
                r_win[sel_gix] <= r_si[SIW-1:0];
            end
        end
        if (r_state == sier_pkg::S_GRP_RD && r_g != GCW'(GROUPS)) begin
            r_pick <= g_pick;
            if (!g_has_pick) begin
                r_g <= r_g + GCW'(1);
            end
        end
        if (r_state == sier_pkg::S_GRP_EV) begin
            r_cache[g_ix] <= sel_rdata[15:0];
            r_g           <= r_g + GCW'(1);
        end
        if (sel_wr && i_entry_bit == sier_pkg::C_FALLBACK_BIT && !r_fb_valid[ld_gix]) begin
            r_fb_idx[ld_gix] <= sel_wr_idx;
        end
    end

    sier_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_emit           (emit),
        .i_evt            (evt),
        .i_flush          (flush),
        .o_strobe         (o_strobe),
        .o_event_kind     (o_event_kind),
        .o_entry_index    (o_entry_index),
        .o_group_number   (o_group_number),
        .o_position_value (o_position_value),
        .o_pressed        (o_pressed),
        .o_forced         (o_forced),
        .o_last_event     (o_last_event)
    );

`ifndef ASSERT_OFF
    a_strobe_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == sier_pkg::S_GRP_EV || r_state == sier_pkg::S_MOM_EV
                           || r_state == sier_pkg::S_DONE)) else $error("strobe outside walk");
    a_mom_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sier_pkg::S_MOM_EV) |-> (r_mi < mom_count)) else $error("momentary overrun");
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sier_pkg::S_DONE) |=> (r_state == sier_pkg::S_IDLE)) else $error("no return");
`endif

endmodule

// ===== hdl/sier_tables.sv =====
// Momentary and selector entry memories with their fill counts.
module sier_tables #(
    parameter int GROUPS      = sier_pkg::C_GROUPS,
    parameter int MOM_ENTRIES = sier_pkg::C_MOM_ENTRIES,
    parameter int SEL_ENTRIES = sier_pkg::C_SEL_ENTRIES,
    localparam int MIW = (MOM_ENTRIES > 1) ? $clog2(MOM_ENTRIES) : 1,
    localparam int SIW = (SEL_ENTRIES > 1) ? $clog2(SEL_ENTRIES) : 1,
    localparam int MCW = $clog2(MOM_ENTRIES + 1),
    localparam int SCW = $clog2(SEL_ENTRIES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sier_pkg::t_load   i_load,
    input  logic [MIW-1:0]    i_mom_addr,
    input  logic [SIW-1:0]    i_sel_addr,
    output logic [5:0]        o_mom_rdata,
    output logic [26:0]       o_sel_rdata,
    output logic [MCW-1:0]    o_mom_count,
    output logic [SCW-1:0]    o_sel_count,
    output logic              o_sel_wr,
    output logic [SIW-1:0]    o_sel_wr_idx
);

    logic [5:0]     r_mom_mem [MOM_ENTRIES];
    logic [26:0]    r_sel_mem [SEL_ENTRIES];
    logic [MCW-1:0] r_mom_count;
    logic [SCW-1:0] r_sel_count;
    logic           mom_wr;

    // Loads that are out of range or find the table full are dropped.
    assign mom_wr = i_load.add_mom && !i_load.bit_pos[6]
                    && (r_mom_count < MCW'(MOM_ENTRIES));
    assign o_sel_wr = i_load.add_sel && (i_load.grp != 4'd0)
                      && (32'(i_load.grp) < GROUPS)
                      && (r_sel_count < SCW'(SEL_ENTRIES));
    assign o_sel_wr_idx = r_sel_count[SIW-1:0];

    // Fill counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_load.clear) begin
            r_mom_count <= '0;
            r_sel_count <= '0;
        end else begin
            if (mom_wr) begin
                r_mom_count <= r_mom_count + MCW'(1);
            end
            if (o_sel_wr) begin
                r_sel_count <= r_sel_count + SCW'(1);
            end
        end
    end

    // Memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (mom_wr) begin
            r_mom_mem[r_mom_count[MIW-1:0]] <= i_load.bit_pos[5:0];
        end
        if (o_sel_wr) begin
            r_sel_mem[r_sel_count[SIW-1:0]] <= {i_load.bit_pos, i_load.grp, i_load.value};
        end
        o_mom_rdata <= r_mom_mem[i_mom_addr];
        o_sel_rdata <= r_sel_mem[i_sel_addr];
    end

    assign o_mom_count = r_mom_count;
    assign o_sel_count = r_sel_count;

endmodule

// ===== hdl/sier_emit.sv =====
// Output stage that holds one event back so that the final one can be marked.
module sier_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_emit,
    input  sier_pkg::t_evt  i_evt,
    input  logic            i_flush,
    output logic            o_strobe,
    output logic            o_event_kind,
    output logic [5:0]      o_entry_index,
    output logic [3:0]      o_group_number,
    output logic [15:0]     o_position_value,
    output logic            o_pressed,
    output logic            o_forced,
    output logic            o_last_event
);

    logic           r_pend_valid;
    sier_pkg::t_evt r_pend;

    // Pending flag and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            o_strobe     <= 1'b0;
        end else begin
            o_strobe <= r_pend_valid && (i_emit || i_flush);
            if (i_emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_emit) begin
            r_pend <= i_evt;
        end
        o_event_kind     <= r_pend.kind;
        o_entry_index    <= r_pend.index;
        o_group_number   <= r_pend.grp;
        o_position_value <= r_pend.value;
        o_pressed        <= r_pend.pressed;
        o_forced         <= r_pend.forced;
        o_last_event     <= i_flush;
    end

`ifndef ASSERT_OFF
    a_no_emit_and_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_emit && i_flush)) else $error("emit and flush together");
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_flush |=> !r_pend_valid) else $error("pending event survived flush");
    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_last_event && o_strobe) |-> $past(i_flush)) else $error("stray last flag");
`endif

endmodule
